@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define DBPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// trigger in this cycle implies consequence in the next cycle
`define DBPS_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

@@ src/dbps_pkg.sv @@
// ----------------------------------------------------------------------------
// dbps_pkg
// Constants, codes and shared types of the DFA byte pattern scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dbps_pkg;

  localparam int NUM_STATES      = 256;
  localparam int MATCH_SLOTS     = 8;
  localparam int POSITION_BITS   = 32;

  localparam int SYMBOL_BITS     = 8;
  localparam int SYMBOLS         = 1 << SYMBOL_BITS;
  localparam int SLOT_LIMIT      = 8;
  localparam int REPORT_SLOTS    = (MATCH_SLOTS < SLOT_LIMIT) ? MATCH_SLOTS : SLOT_LIMIT;
  localparam int STATE_BITS      = $clog2(NUM_STATES);
  localparam int TRANS_DEPTH     = NUM_STATES * SYMBOLS;
  localparam int OFFSET_BITS     = 32;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_LOAD_TRANS = 2'd0,
    KIND_LOAD_SLOT  = 2'd1,
    KIND_START      = 2'd2,
    KIND_DATA       = 2'd3
  } kind_t;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TRANS,
    ST_SLOTS,
    ST_EMIT
  } state_t;

  // one match slot as stored in a bank
  typedef struct packed {
    logic       valid;
    logic [7:0] id;
    logic [7:0] len;
  } slot_entry_t;

  localparam int SLOT_ENTRY_BITS = $bits(slot_entry_t);

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load_trans;
    logic load_slot;
    logic start;
    logic trans_rd;
    logic step;
    logic capture;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic any_match;
    logic last_pending;
    logic out_free;
  } status_t;

endpackage

@@ src/dbps_ram.sv @@
// ----------------------------------------------------------------------------
// dbps_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/dbps_ctrl.sv @@
// ----------------------------------------------------------------------------
// dbps_ctrl
// Sequencer: slot clearing after reset, item decode, read and emit steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_kind,
  input  dbps_pkg::status_t status,
  output dbps_pkg::cmd_t    cmd,
  output logic              in_stall
);

  import dbps_pkg::*;

  state_t state_r, state_nxt;
  kind_t  kind;

  assign kind = kind_t'(in_kind);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (status.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (kind) inside
            KIND_START:                     state_nxt = ST_SLOTS;
            KIND_DATA:                      state_nxt = ST_TRANS;
            KIND_LOAD_TRANS, KIND_LOAD_SLOT: state_nxt = ST_IDLE;
            default:                        state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_TRANS: state_nxt = ST_SLOTS;
      ST_SLOTS: begin
        state_nxt = status.any_match ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status.out_free && status.last_pending) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (kind)
            KIND_LOAD_TRANS: cmd.load_trans = 1'b1;
            KIND_LOAD_SLOT:  cmd.load_slot  = 1'b1;
            KIND_START:      cmd.start      = 1'b1;
            KIND_DATA:       cmd.trans_rd   = 1'b1;
            default:         cmd            = '0;
          endcase
        end
      end
      ST_TRANS: cmd.step    = 1'b1;
      ST_SLOTS: cmd.capture = 1'b1;
      ST_EMIT:  cmd.emit    = status.out_free;
      default:  cmd         = '0;
    endcase
  end

endmodule

@@ src/dbps_datapath.sv @@
// ----------------------------------------------------------------------------
// dbps_datapath
// Transition RAM, banked match slot RAMs, scan state and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbps_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  dbps_pkg::cmd_t    cmd,
  output dbps_pkg::status_t status,
  input  logic [7:0]        in_state_index,
  input  logic [7:0]        in_byte_value,
  input  logic [7:0]        in_next_state,
  input  logic [2:0]        in_slot,
  input  logic              in_slot_valid,
  input  logic [7:0]        in_pattern_id,
  input  logic [7:0]        in_pattern_length,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [7:0]        out_match_pattern,
  output logic [31:0]       out_start_offset,
  output logic              out_last
);

  import dbps_pkg::*;

  logic [STATE_BITS-1:0]    clear_cnt_r, clear_cnt_nxt;
  logic [STATE_BITS-1:0]    cur_state_r, cur_state_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [REPORT_SLOTS-1:0]  mask_r, mask_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               out_pattern_r;
  logic [OFFSET_BITS-1:0]   out_offset_r;
  logic                     out_last_r;

  slot_entry_t              slot_r [REPORT_SLOTS];
  slot_entry_t              bank_rdata [REPORT_SLOTS];
  logic [REPORT_SLOTS-1:0]  bank_valid;

  logic                     state_ok;
  logic                     slot_ok;
  logic [STATE_BITS-1:0]    load_state;
  logic [7:0]               trans_rdata;
  logic [STATE_BITS-1:0]    step_state;
  logic                     bank_re;
  logic [STATE_BITS-1:0]    bank_raddr;
  logic [STATE_BITS-1:0]    bank_waddr;
  slot_entry_t              bank_wdata;
  logic [REPORT_SLOTS-1:0]  sel;
  logic [REPORT_SLOTS-1:0]  mask_rest;
  slot_entry_t              sel_entry;
  logic                     out_free;

  // load address checks (out of range loads are dropped)
  assign state_ok   = (32'(in_state_index) < NUM_STATES);
  assign slot_ok    = (32'(in_slot) < MATCH_SLOTS);
  assign load_state = STATE_BITS'(in_state_index);

  // transition table
  dbps_ram #(
    .WIDTH (8),
    .DEPTH (TRANS_DEPTH)
  ) u_trans_ram (
    .clk   (clk),
    .we    (cmd.load_trans && state_ok),
    .waddr ({load_state, in_byte_value}),
    .wdata (in_next_state),
    .re    (cmd.trans_rd),
    .raddr ({cur_state_r, in_byte_value}),
    .rdata (trans_rdata)
  );

  // targets beyond the state count fall back to root
  assign step_state = (32'(trans_rdata) < NUM_STATES) ? STATE_BITS'(trans_rdata) : '0;

  // match slot banks, one per reportable slot, addressed by state
  assign bank_re    = cmd.start || cmd.step;
  assign bank_raddr = cmd.start ? '0 : step_state;
  assign bank_waddr = cmd.clear ? clear_cnt_r : load_state;
  assign bank_wdata = cmd.clear ? '0 : {in_slot_valid, in_pattern_id, in_pattern_length};

  for (genvar i = 0; i < REPORT_SLOTS; i++) begin : g_bank
    logic                       bank_we;
    logic [SLOT_ENTRY_BITS-1:0] rdata_bits;

    assign bank_we = cmd.clear ||
                     (cmd.load_slot && state_ok && slot_ok && (32'(in_slot) == i));

    dbps_ram #(
      .WIDTH (SLOT_ENTRY_BITS),
      .DEPTH (NUM_STATES)
    ) u_slot_ram (
      .clk   (clk),
      .we    (bank_we),
      .waddr (bank_waddr),
      .wdata (bank_wdata),
      .re    (bank_re),
      .raddr (bank_raddr),
      .rdata (rdata_bits)
    );

    assign bank_rdata[i] = slot_entry_t'(rdata_bits);
    assign bank_valid[i] = bank_rdata[i].valid;
  end

  // lowest pending slot goes out first
  always_comb begin
    logic found;
    found     = 1'b0;
    sel       = '0;
    sel_entry = '0;
    for (int i = 0; i < REPORT_SLOTS; i++) begin
      if (mask_r[i] && !found) begin
        sel[i]    = 1'b1;
        sel_entry = slot_r[i];
        found     = 1'b1;
      end
    end
  end

  assign mask_rest = mask_r & ~sel;
  assign out_free  = !out_valid_r || !out_stall;

  // next values of the control registers
  always_comb begin
    clear_cnt_nxt = clear_cnt_r;
    cur_state_nxt = cur_state_r;
    pos_nxt       = pos_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r;

    if (cmd.clear) clear_cnt_nxt = clear_cnt_r + STATE_BITS'(1);

    if (cmd.start) begin
      cur_state_nxt = '0;
      pos_nxt       = '0;
    end else if (cmd.step) begin
      cur_state_nxt = step_state;
      pos_nxt       = pos_r + POSITION_BITS'(1);
    end

    if (cmd.capture) begin
      mask_nxt = bank_valid;
    end else if (cmd.emit) begin
      mask_nxt = mask_rest;
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_cnt_r <= '0;
      cur_state_r <= '0;
      pos_r       <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clear_cnt_r <= clear_cnt_nxt;
      cur_state_r <= cur_state_nxt;
      pos_r       <= pos_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: captured slots and result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < REPORT_SLOTS; i++) begin
        slot_r[i] <= bank_rdata[i];
      end
    end
    if (cmd.emit) begin
      out_pattern_r <= sel_entry.id;
      out_offset_r  <= OFFSET_BITS'(pos_r - POSITION_BITS'(sel_entry.len));
      out_last_r    <= (mask_rest == '0);
    end
  end

  assign status.clear_done   = (clear_cnt_r == STATE_BITS'(NUM_STATES - 1));
  assign status.any_match    = |bank_valid;
  assign status.last_pending = (mask_rest == '0);
  assign status.out_free     = out_free;

  assign out_valid         = out_valid_r;
  assign out_match_pattern = out_pattern_r;
  assign out_start_offset  = out_offset_r;
  assign out_last          = out_last_r;

endmodule

@@ src/dfa_byte_pattern_scanner.sv @@
// ----------------------------------------------------------------------------
// dfa_byte_pattern_scanner
// Multi-pattern byte scanner driven by a loaded DFA with per-state match slots.
// ----------------------------------------------------------------------------
// Load items finish in the idle state. A start item passes idle and slot
// capture; a data byte passes idle, the transition step and slot capture
// (transition RAM read, then slot bank read); each match reported adds
// an emit step, which out_stall can hold.
// Reset: synchronous, active low; a clearing pass over all NUM_STATES (256)
// slot addresses invalidates all match slots, with in_stall high until it finishes.
`timescale 1ns / 1ps

module dfa_byte_pattern_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_state_index,
  input  logic [7:0]  in_byte_value,
  input  logic [7:0]  in_next_state,
  input  logic [2:0]  in_slot,
  input  logic        in_slot_valid,
  input  logic [7:0]  in_pattern_id,
  input  logic [7:0]  in_pattern_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_match_pattern,
  output logic [31:0] out_start_offset,
  output logic        out_last
);

  import dbps_pkg::*;

  cmd_t    cmd;
  status_t status;

  dbps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  dbps_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_state_index    (in_state_index),
    .in_byte_value     (in_byte_value),
    .in_next_state     (in_next_state),
    .in_slot           (in_slot),
    .in_slot_valid     (in_slot_valid),
    .in_pattern_id     (in_pattern_id),
    .in_pattern_length (in_pattern_length),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_match_pattern (out_match_pattern),
    .out_start_offset  (out_start_offset),
    .out_last          (out_last)
  );

endmodule

@@ src/dbps_checker.sv @@
// ----------------------------------------------------------------------------
// dbps_checker
// Port-level assertions for the scanner, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dbps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_kind,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_match_pattern,
  input logic [31:0] out_start_offset,
  input logic        out_last
);

  import dbps_pkg::*;

  logic        in_acc;
  logic        load_acc;
  logic        data_acc;
  logic        out_held;
  logic [40:0] out_payload;

  assign in_acc   = in_valid && !in_stall;
  assign load_acc = in_acc && (in_kind == KIND_LOAD_TRANS || in_kind == KIND_LOAD_SLOT);
  assign data_acc = in_acc && (in_kind == KIND_DATA);

  // result fields as one word
  assign out_held    = out_valid && out_stall;
  assign out_payload = {out_match_pattern, out_start_offset, out_last};

  // a held result keeps its payload
  `DBPS_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_payload), "held result changed")

  // load items never produce a result
  `DBPS_ASSERT_NEXT(a_load_silent, load_acc && !out_valid, !out_valid, "result after load item")

  // a data byte occupies the block for its two RAM reads
  `DBPS_ASSERT(a_data_busy, data_acc |=> in_stall ##1 in_stall, "input taken during byte lookup")

endmodule

bind dfa_byte_pattern_scanner dbps_checker u_checker (.*);

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dfa_byte_pattern_scanner. A mirror of the DFA tables
// predicts every match result of each accepted item. Results are checked in
// order against a queue, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import dbps_pkg::*;

  localparam int RANDOM_ITEMS = 300;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 100;

  // one expected match result
  typedef struct {
    logic [7:0]             pattern;
    logic [OFFSET_BITS-1:0] offset;
    logic                   last;
  } match_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = 2'd0;
  logic [7:0]  in_state_index = 8'd0;
  logic [7:0]  in_byte_value = 8'd0;
  logic [7:0]  in_next_state = 8'd0;
  logic [2:0]  in_slot = 3'd0;
  logic        in_slot_valid = 1'b0;
  logic [7:0]  in_pattern_id = 8'd0;
  logic [7:0]  in_pattern_length = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_match_pattern;
  logic [31:0] out_start_offset;
  logic        out_last;

  // mirror of the scanner state
  logic [7:0]               dfa_next [NUM_STATES][SYMBOLS];
  bit                       dfa_known [NUM_STATES][SYMBOLS];
  slot_entry_t              slot_bank [NUM_STATES][MATCH_SLOTS];
  logic [STATE_BITS-1:0]    scan_state;
  logic [POSITION_BITS-1:0] scan_pos;
  match_rec_t               expected_matches[$];

  int  mismatch_count = 0;
  int  hold_asks = 0;
  int  hold_done = 0;
  bit  rx_holding = 1'b0;
  bit  rx_quiet = 1'b0;
  bit  tx_quiet = 1'b0;

  // small alphabet so the scan mostly follows known edges
  logic [7:0] common_syms [6] = '{8'h00, 8'h01, 8'h41, 8'h5A, 8'h80, 8'hFF};

  dfa_byte_pattern_scanner dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_state_index    (in_state_index),
    .in_byte_value     (in_byte_value),
    .in_next_state     (in_next_state),
    .in_slot           (in_slot),
    .in_slot_valid     (in_slot_valid),
    .in_pattern_id     (in_pattern_id),
    .in_pattern_length (in_pattern_length),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_match_pattern (out_match_pattern),
    .out_start_offset  (out_start_offset),
    .out_last          (out_last)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // queue one result per valid slot of the current state, last on the final one
  task automatic queue_state_matches();
    int         last_slot;
    match_rec_t rec;
    last_slot = -1;
    for (int s = 0; s < REPORT_SLOTS; s++)
      if (slot_bank[scan_state][s].valid) last_slot = s;
    for (int s = 0; s < REPORT_SLOTS; s++) begin
      if (slot_bank[scan_state][s].valid) begin
        rec.pattern = slot_bank[scan_state][s].id;
        rec.offset  = OFFSET_BITS'(scan_pos - POSITION_BITS'(slot_bank[scan_state][s].len));
        rec.last    = (s == last_slot);
        expected_matches.push_back(rec);
      end
    end
  endtask

  task automatic advance_scanner(input kind_t kind, input logic [7:0] sidx,
                                 input logic [7:0] sym, input logic [7:0] nxt,
                                 input logic [2:0] sl, input logic sv,
                                 input logic [7:0] pid, input logic [7:0] plen);
    int target;
    case (kind)
      KIND_LOAD_TRANS: begin
        if (sidx < NUM_STATES) begin
          dfa_next[sidx][sym]  = nxt;
          dfa_known[sidx][sym] = 1'b1;
        end
      end
      KIND_LOAD_SLOT: begin
        if (sidx < NUM_STATES && sl < MATCH_SLOTS) begin
          slot_bank[sidx][sl].valid = sv;
          slot_bank[sidx][sl].id    = pid;
          slot_bank[sidx][sl].len   = plen;
        end
      end
      KIND_START: begin
        scan_state = '0;
        scan_pos   = '0;
        queue_state_matches();
      end
      default: begin
        target     = dfa_next[scan_state][sym];
        scan_state = (target < NUM_STATES) ? STATE_BITS'(target) : '0;
        scan_pos   = scan_pos + POSITION_BITS'(1);
        queue_state_matches();
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // targets mostly in a small cluster of states, so matches come often
  function automatic logic [7:0] pick_target();
    if ($urandom_range(0, 99) < 80) return 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(0, 99) < 70) return common_syms[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  // present one item and hold it until accepted, then update the mirror
  task automatic offer_item(input kind_t kind, input logic [7:0] sidx,
                            input logic [7:0] sym, input logic [7:0] nxt,
                            input logic [2:0] sl, input logic sv,
                            input logic [7:0] pid, input logic [7:0] plen);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_kind           <= kind;
    in_state_index    <= sidx;
    in_byte_value     <= sym;
    in_next_state     <= nxt;
    in_slot           <= sl;
    in_slot_valid     <= sv;
    in_pattern_id     <= pid;
    in_pattern_length <= plen;
    do @(posedge clk); while (in_stall !== 1'b0);
    advance_scanner(kind, sidx, sym, nxt, sl, sv, pid, plen);
  endtask

  task automatic load_trans(input logic [7:0] st, input logic [7:0] sym,
                            input logic [7:0] nxt);
    offer_item(KIND_LOAD_TRANS, st, sym, nxt, 3'($urandom), 1'($urandom),
               8'($urandom), 8'($urandom));
  endtask

  task automatic load_slot(input logic [7:0] st, input logic [2:0] sl, input logic sv,
                           input logic [7:0] pid, input logic [7:0] plen);
    offer_item(KIND_LOAD_SLOT, st, 8'($urandom), 8'($urandom), sl, sv, pid, plen);
  endtask

  task automatic start_scan();
    offer_item(KIND_START, 8'($urandom), 8'($urandom), 8'($urandom), 3'($urandom),
               1'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // never follow an unwritten edge: write it first if needed
  task automatic scan_byte(input logic [7:0] sym);
    if (!dfa_known[scan_state][sym]) load_trans(8'(scan_state), sym, pick_target());
    offer_item(KIND_DATA, 8'($urandom), sym, 8'($urandom), 3'($urandom),
               1'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // data right after reset scans from the root at position 0
  task automatic test_scan_without_start();
    load_trans(8'd0, 8'h41, 8'd1);
    load_slot(8'd1, 3'd0, 1'b1, 8'hA5, 8'd1);
    scan_byte(8'h41);
  endtask

  // start reports root matches; length above position wraps the offset
  task automatic test_start_root_matches();
    load_slot(8'd0, 3'd7, 1'b1, 8'hFF, 8'hFF);
    start_scan();
    load_slot(8'd0, 3'd7, 1'b0, 8'h00, 8'h00);
    start_scan();
  endtask

  // a state with every slot valid gives the longest result burst
  task automatic test_all_slots();
    for (int s = 0; s < MATCH_SLOTS; s++)
      load_slot(8'd2, 3'(s), 1'b1, 8'(s * 37), (s == 7) ? 8'hFF : 8'(s));
    load_trans(8'd1, 8'hFF, 8'd2);
    start_scan();
    scan_byte(8'h41);
    scan_byte(8'hFF);
  endtask

  // state with only an invalid slot reports nothing
  task automatic test_no_match();
    load_trans(8'd2, 8'h00, 8'd3);
    load_slot(8'd3, 3'd0, 1'b0, 8'hFF, 8'hFF);
    scan_byte(8'h00);
  endtask

  // highest state, byte and target values, self loop at the top state
  task automatic test_extreme_states();
    load_trans(8'd3, 8'h80, 8'hFF);
    load_trans(8'hFF, 8'hFF, 8'hFF);
    load_slot(8'hFF, 3'd7, 1'b1, 8'h3C, 8'h00);
    scan_byte(8'h80);
    scan_byte(8'hFF);
    start_scan();
  endtask

  // receiver holds off while the sender keeps offering matching bytes
  task automatic test_output_backpressure();
    load_trans(8'd0, 8'h5A, 8'd4);
    load_trans(8'd4, 8'h5A, 8'd4);
    load_slot(8'd4, 3'd0, 1'b1, 8'h11, 8'd2);
    load_slot(8'd4, 3'd3, 1'b1, 8'h22, 8'd5);
    start_scan();
    in_valid <= 1'b0;
    hold_asks++;
    while (!rx_holding) @(posedge clk);
    tx_quiet = 1'b1;
    repeat (40) scan_byte(8'h5A);
    tx_quiet = 1'b0;
  endtask

  // mostly well-formed scans, mixed with slot rewrites and stray table writes
  task automatic test_random_traffic();
    int r;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      rx_quiet = (n >= 240 && n < 320);
      tx_quiet = rx_quiet;
      r = $urandom_range(0, 99);
      if (r < 62) begin
        scan_byte(pick_symbol());
      end else if (r < 69) begin
        start_scan();
      end else if (r < 84) begin
        load_slot(pick_target(), 3'($urandom), ($urandom_range(0, 3) != 0), 8'($urandom),
                  ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 8))
                                               : 8'($urandom_range(0, 255)));
      end else begin
        load_trans(8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    rx_quiet = 1'b0;
    tx_quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, plus one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    int r;
    int stall_len;
    int free_len;
    @(posedge clk);
    forever begin
      if (hold_asks != hold_done) begin
        hold_done++;
        rx_holding = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_holding = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (rx_quiet || r < 50) stall_len = 0;
        else if (r < 88) stall_len = $urandom_range(1, 3);
        else stall_len = $urandom_range(10, 40);
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      r = $urandom_range(0, 99);
      free_len = rx_quiet ? 1 : ((r < 65) ? $urandom_range(1, 4) : $urandom_range(5, 15));
      repeat (free_len) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    match_rec_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_matches.size() == 0) begin
        report_mismatch($sformatf("unexpected result pattern %0h offset %0h last %0b",
                                  out_match_pattern, out_start_offset, out_last));
      end else begin
        want = expected_matches.pop_front();
        if (out_match_pattern !== want.pattern)
          report_mismatch($sformatf("match_pattern %0h, want %0h",
                                    out_match_pattern, want.pattern));
        if (out_start_offset !== want.offset)
          report_mismatch($sformatf("start_offset %0h, want %0h",
                                    out_start_offset, want.offset));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", out_last, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < NUM_STATES; i++)
      for (int j = 0; j < MATCH_SLOTS; j++)
        slot_bank[i][j] = '0;
    scan_state = '0;
    scan_pos   = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_scan_without_start();
    test_start_root_matches();
    test_all_slots();
    test_no_match();
    test_extreme_states();
    test_output_backpressure();
    test_random_traffic();

    in_valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
